>>> src/brasum_pkg.sv
package brasum_pkg;

   localparam int DEF_BUCKET_SIZE = 512;
   localparam int DEF_NUM_BUCKETS = 8;

   localparam int DATA_W  = 64;
   localparam int VALUE_W = 32;
   localparam int START_W = 12;
   localparam int LEN_W   = 13;
   localparam int CSR_W   = 32;
   localparam int PADDR_W = 3;

   localparam logic [LEN_W-1:0] ACTIVE_LENGTH_RESET = 13'd4096;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_ACTIVE_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_ASSIGN = 2'd1,
      OP_SUM    = 2'd2,
      OP_FILL   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BKT,
      ST_MUL,
      ST_WHOLE,
      ST_SUMT,
      ST_WALK,
      ST_FIN,
      ST_NEXT,
      ST_OUT,
      ST_FILL
   } st_type;

endpackage

>>> src/bucketed_range_add_assign_sum.sv
// Range add / range assign / range sum / fill over a store of signed 64-bit elements,
// split into NUM_BUCKETS buckets of BUCKET_SIZE elements.
// Request word (req_*): op, range_start, range_end, value; taken on req_valid & req_ready.
// Response word (rsp_*): range_sum, one per sum request only.
// CSR port: active_length at address 0, written with psel/penable/pwrite, pready tied high.
// One request is worked at a time; req_ready is high only while the sequencer is idle.
// A bucket that is missed, or added to as a whole, passes ST_BKT and ST_NEXT only; a whole
// sum also passes ST_MUL, ST_WHOLE and ST_SUMT, a whole assign ST_MUL and ST_WHOLE. A bucket
// touched in part is walked through the element RAM, one element per cycle through its single
// read and write port. Fill passes only ST_MUL and ST_FILL.
// A sum result sits in the output register until rsp_ready; the next request may be
// taken meanwhile, and a following sum waits at its end for the register to free up.
// Reset (synchronous) marks every bucket as assigned to zero, so the element RAM needs
// no clearing pass; active_length returns to 4096.
module bucketed_range_add_assign_sum
   import brasum_pkg::*;
#(
   parameter int BUCKET_SIZE = DEF_BUCKET_SIZE,
   parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_op,
   input  logic [START_W-1:0]        req_range_start,
   input  logic [LEN_W-1:0]          req_range_end,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DATA_W-1:0]  rsp_range_sum,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [CSR_W-1:0]          pwdata,
   output logic [CSR_W-1:0]          prdata,
   output logic                      pready
);

   localparam int DEPTH = BUCKET_SIZE * NUM_BUCKETS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
   localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int BSW   = $clog2(BUCKET_SIZE + 1);
   localparam logic [PW-1:0]  BS_P   = PW'(BUCKET_SIZE);
   localparam logic [BSW-1:0] BS_M   = BSW'(BUCKET_SIZE);
   localparam logic [BW-1:0]  LAST_B = BW'(NUM_BUCKETS - 1);

   st_type state_ff, state_in;

   op_type              op_ff;
   logic [PW-1:0]       s_ff, t_ff, lo_ff, hi_ff, idx_ff, end_ff;
   logic [DATA_W-1:0]   x_ff, sum_ff, acc_ff, prod_ff, rd_data_ff;
   logic [BW-1:0]       b_ff;
   logic                p1_v_ff, p1_inr_ff, p2_v_ff;
   logic [AW-1:0]       p1_addr_ff;
   logic [DATA_W-1:0]   p2_contrib_ff;
   logic [LEN_W-1:0]    active_len_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_sum_ff;

   logic [DATA_W-1:0]   element_store_ff [DEPTH];
   logic [DATA_W-1:0]   total_ff  [NUM_BUCKETS];
   logic [DATA_W-1:0]   addend_ff [NUM_BUCKETS];
   logic [DATA_W-1:0]   av_ff     [NUM_BUCKETS];
   logic                pend_ff   [NUM_BUCKETS];

   logic [DATA_W-1:0]       cur_total, cur_addend, cur_av;
   logic                    cur_pend;
   logic                    hit, whole, full_walk, issue_en, out_load, csr_wr;
   logic [PW-1:0]           walk_lo, walk_hi;
   logic [DATA_W-1:0]       mul_a, base, p1_new, p1_contrib, x_in;
   logic [DATA_W+BSW-1:0]   mul_full;

   assign cur_total  = total_ff[b_ff];
   assign cur_addend = addend_ff[b_ff];
   assign cur_av     = av_ff[b_ff];
   assign cur_pend   = pend_ff[b_ff];

   assign hit       = (lo_ff < PW'(active_len_ff)) && (hi_ff > s_ff) && (t_ff > lo_ff);
   assign whole     = (s_ff <= lo_ff) && (hi_ff <= t_ff);
   assign full_walk = cur_pend || (op_ff == OP_ASSIGN);
   assign walk_lo   = full_walk ? lo_ff : ((s_ff > lo_ff) ? s_ff : lo_ff);
   assign walk_hi   = full_walk ? hi_ff : ((t_ff < hi_ff) ? t_ff : hi_ff);
   assign issue_en  = (state_ff == ST_WALK) && (idx_ff < end_ff);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign csr_wr    = psel && penable && pwrite && (paddr[2] == CSR_IDX_ACTIVE_LENGTH);
   assign x_in      = {{(DATA_W-VALUE_W){req_value[VALUE_W-1]}}, req_value};

   // shared multiplier: value or bucket addend times bucket size
   assign mul_a    = (op_ff == OP_SUM) ? cur_addend : x_ff;
   assign mul_full = mul_a * BS_M;

   // element walk, data stage
   always_comb begin
      base = cur_pend ? cur_av : rd_data_ff;
      unique case (op_ff)
         OP_ADD: begin
            p1_contrib = p1_inr_ff ? x_ff : '0;
            p1_new     = base + p1_contrib;
         end
         OP_ASSIGN: begin
            p1_new     = p1_inr_ff ? x_ff : base + cur_addend;
            p1_contrib = p1_new;
         end
         OP_SUM: begin
            p1_new     = base;
            p1_contrib = p1_inr_ff ? base + cur_addend : '0;
         end
         default: begin
            p1_new     = base;
            p1_contrib = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (op_type'(req_op) == OP_FILL) ? ST_MUL : ST_BKT;
            end
         end
         ST_BKT: begin
            if (!hit) begin
               state_in = ST_NEXT;
            end else if (whole) begin
               state_in = (op_ff == OP_ADD) ? ST_NEXT : ST_MUL;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_MUL:   state_in = (op_ff == OP_FILL) ? ST_FILL : ST_WHOLE;
         ST_WHOLE: state_in = (op_ff == OP_SUM) ? ST_SUMT : ST_NEXT;
         ST_SUMT:  state_in = ST_NEXT;
         ST_WALK: begin
            if (!issue_en && !p1_v_ff && !p2_v_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:   state_in = ST_NEXT;
         ST_NEXT: begin
            if (b_ff == LAST_B) begin
               state_in = (op_ff == OP_SUM) ? ST_OUT : ST_IDLE;
            end else begin
               state_in = ST_BKT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff  <= op_type'(req_op);
         s_ff   <= PW'(req_range_start);
         t_ff   <= PW'(req_range_end);
         x_ff   <= x_in;
         b_ff   <= '0;
         lo_ff  <= '0;
         hi_ff  <= BS_P;
         sum_ff <= '0;
      end
      if (state_ff == ST_BKT) begin
         idx_ff <= walk_lo;
         end_ff <= walk_hi;
         unique case (op_ff)
            OP_ADD:  acc_ff <= cur_total;
            OP_SUM:  acc_ff <= sum_ff;
            default: acc_ff <= '0;
         endcase
      end
      if (issue_en) begin
         idx_ff <= idx_ff + PW'(1);
      end
      if (p2_v_ff) begin
         acc_ff <= acc_ff + p2_contrib_ff;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= mul_full[DATA_W-1:0];
      end
      if (state_ff == ST_WHOLE && op_ff == OP_SUM) begin
         sum_ff <= sum_ff + prod_ff;
      end
      if (state_ff == ST_SUMT) begin
         sum_ff <= sum_ff + cur_total;
      end
      if (state_ff == ST_FIN && op_ff == OP_SUM) begin
         sum_ff <= acc_ff;
      end
      if (state_ff == ST_NEXT && b_ff != LAST_B) begin
         b_ff  <= b_ff + BW'(1);
         lo_ff <= hi_ff;
         hi_ff <= hi_ff + BS_P;
      end
      p1_inr_ff     <= (idx_ff >= s_ff) && (idx_ff < t_ff);
      p1_addr_ff    <= idx_ff[AW-1:0];
      p2_contrib_ff <= p1_contrib;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= issue_en;
         p2_v_ff <= p1_v_ff;
      end
   end

   // element RAM: one read port, one write port
   always_ff @(posedge clock) begin
      if (issue_en) begin
         rd_data_ff <= element_store_ff[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (p1_v_ff) begin
         element_store_ff[p1_addr_ff] <= p1_new;
      end
   end

   // per-bucket lazy state; reset leaves every bucket assigned to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            total_ff[i]  <= '0;
            addend_ff[i] <= '0;
            av_ff[i]     <= '0;
            pend_ff[i]   <= 1'b1;
         end
      end else begin
         unique case (state_ff)
            ST_BKT: begin
               if (hit && whole && op_ff == OP_ADD) begin
                  addend_ff[b_ff] <= cur_addend + x_ff;
               end
            end
            ST_WHOLE: begin
               if (op_ff == OP_ASSIGN) begin
                  total_ff[b_ff]  <= prod_ff;
                  addend_ff[b_ff] <= '0;
                  av_ff[b_ff]     <= x_ff;
                  pend_ff[b_ff]   <= 1'b1;
               end
            end
            ST_FIN: begin
               pend_ff[b_ff] <= 1'b0;
               if (op_ff == OP_ADD || op_ff == OP_ASSIGN) begin
                  total_ff[b_ff] <= acc_ff;
               end
               if (op_ff == OP_ASSIGN) begin
                  addend_ff[b_ff] <= '0;
               end
            end
            ST_FILL: begin
               for (int i = 0; i < NUM_BUCKETS; i++) begin
                  total_ff[i]  <= prod_ff;
                  addend_ff[i] <= '0;
                  av_ff[i]     <= x_ff;
                  pend_ff[i]   <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sum_ff <= sum_ff;
      end
   end

   // CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         active_len_ff <= ACTIVE_LENGTH_RESET;
      end else if (csr_wr) begin
         active_len_ff <= pwdata[LEN_W-1:0];
      end
   end

   assign prdata        = (paddr[2] == CSR_IDX_ACTIVE_LENGTH) ? CSR_W'(active_len_ff) : '0;
   assign pready        = 1'b1;
   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

endmodule

>>> tb/sv/tb_bucketed_range_add_assign_sum.sv
`timescale 1ns / 100ps

module tb_bucketed_range_add_assign_sum;
   import brasum_pkg::*;

   localparam int STORE_DEPTH = DEF_BUCKET_SIZE * DEF_NUM_BUCKETS;
   localparam int DRAIN_CYCLES = 1200;
   localparam int WDOG_LIMIT = 20000;
   localparam int N_PHASES = 7;
   localparam int WORDS_PER_PHASE = 38;
   localparam int N_ROWS = 26;
   localparam logic [PADDR_W-1:0] ADDR_ACTIVE_LENGTH = {CSR_IDX_ACTIVE_LENGTH, 2'b00};

   typedef struct {
      op_type      op;
      int          s;
      int          e;
      logic [31:0] v;
      bit          chk;
      logic [63:0] sum;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_op;
   logic [START_W-1:0]        req_range_start;
   logic [LEN_W-1:0]          req_range_end;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [DATA_W-1:0]  rsp_range_sum;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [PADDR_W-1:0]        paddr;
   logic [CSR_W-1:0]          pwdata;
   logic [CSR_W-1:0]          prdata;
   logic                      pready;

   logic [63:0] elem_shadow [STORE_DEPTH];
   logic [LEN_W-1:0] shadow_len;
   logic [63:0] pending_sums [$];
   bit          tag_chk;
   logic [63:0] tag_sum;
   bit          idle_on;
   int          n_errs;
   int          quiet_cycles;

   stim_row_type dir_rows [N_ROWS] = '{
      '{OP_SUM,    0,    4096, 32'h0000_0000, 1, 64'h0},
      '{OP_FILL,   0,    0,    32'h7FFF_FFFF, 0, 64'h0},
      '{OP_SUM,    0,    4096, 32'h0000_0000, 1, 64'h0000_07FF_FFFF_F000},
      '{OP_SUM,    4095, 4096, 32'h0000_0000, 1, 64'h0000_0000_7FFF_FFFF},
      '{OP_FILL,   4095, 0,    32'h8000_0000, 0, 64'h0},
      '{OP_SUM,    0,    4096, 32'h0000_0000, 1, 64'hFFFF_F800_0000_0000},
      '{OP_SUM,    100,  100,  32'h0000_0000, 1, 64'h0},
      '{OP_SUM,    4095, 0,    32'h0000_0000, 1, 64'h0},
      '{OP_ADD,    0,    4096, 32'h0000_0001, 0, 64'h0},
      '{OP_ADD,    3,    700,  32'hFFFF_FFFF, 0, 64'h0},
      '{OP_ASSIGN, 512,  1024, 32'h0000_0005, 0, 64'h0},
      '{OP_SUM,    510,  1030, 32'h0000_0000, 0, 64'h0},
      '{OP_ASSIGN, 1536, 2048, 32'h0000_0009, 0, 64'h0},
      '{OP_ADD,    1600, 1700, 32'h0000_0002, 0, 64'h0},
      '{OP_SUM,    1536, 2048, 32'h0000_0000, 0, 64'h0},
      '{OP_ASSIGN, 1000, 1500, 32'hFFFF_FFF9, 0, 64'h0},
      '{OP_ADD,    0,    4096, 32'h0000_0003, 0, 64'h0},
      '{OP_SUM,    1400, 2100, 32'h0000_0000, 0, 64'h0},
      '{OP_ASSIGN, 4095, 4096, 32'h7FFF_FFFF, 0, 64'h0},
      '{OP_SUM,    0,    4096, 32'h0000_0000, 0, 64'h0},
      '{OP_ADD,    2048, 4096, 32'h8000_0000, 0, 64'h0},
      '{OP_SUM,    2047, 4096, 32'hFFFF_FFFF, 0, 64'h0},
      '{OP_FILL,   4095, 0,    32'h0000_0000, 0, 64'h0},
      '{OP_SUM,    0,    4096, 32'h0000_0000, 1, 64'h0},
      '{OP_ASSIGN, 0,    4096, 32'hFFFF_FFFF, 0, 64'h0},
      '{OP_SUM,    0,    4096, 32'h0000_0000, 1, 64'hFFFF_FFFF_FFFF_F000}
   };

   int len_sets [N_PHASES] = '{4096, 1, 0, 513, 8191, 1500, 4096};

   bucketed_range_add_assign_sum dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_sum   (rsp_range_sum),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // flat element array; add, assign and sum touch only active buckets, fill writes every element; wrapping mod 2^64
   task automatic apply_range_op(input op_type op, input int s, input int e,
                                 input logic [31:0] v, output bit gives,
                                 output logic [63:0] total);
      logic [63:0] x;
      int len;
      int top;
      int hi;
      x = {{32{v[31]}}, v};
      total = '0;
      gives = (op == OP_SUM);
      if (op == OP_FILL) begin
         for (int i = 0; i < STORE_DEPTH; i++) elem_shadow[i] = x;
         return;
      end
      len = (shadow_len > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_len);
      top = ((len + DEF_BUCKET_SIZE - 1) / DEF_BUCKET_SIZE) * DEF_BUCKET_SIZE;
      hi = (e < top) ? e : top;
      for (int i = s; i < hi; i++) begin
         case (op)
            OP_ADD:    elem_shadow[i] = elem_shadow[i] + x;
            OP_ASSIGN: elem_shadow[i] = x;
            default:   total = total + elem_shadow[i];
         endcase
      end
   endtask

   always @(posedge clock) begin
      bit gives;
      logic [63:0] total;
      logic [63:0] want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            moved = 1'b1;
            if (paddr[2] == CSR_IDX_ACTIVE_LENGTH) shadow_len = pwdata[LEN_W-1:0];
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            apply_range_op(op_type'(req_op), int'(req_range_start), int'(req_range_end),
                           req_value, gives, total);
            if (gives) pending_sums.push_back(tag_chk ? tag_sum : total);
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (pending_sums.size() == 0) begin
               n_errs++;
               $display("%0t: unexpected sum word, expected none actual %h",
                        $time, rsp_range_sum);
            end else begin
               want = pending_sums.pop_front();
               if (rsp_range_sum !== want) begin
                  n_errs++;
                  $display("%0t: range_sum mismatch, expected %h actual %h",
                           $time, want, rsp_range_sum);
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[bucketed_range_add_assign_sum] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_word(input op_type op, input int s, input int e,
                            input logic [31:0] v, input bit chk, input logic [63:0] sum);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op = op;
      req_range_start = s[START_W-1:0];
      req_range_end = e[LEN_W-1:0];
      req_value = v;
      tag_chk = chk;
      tag_sum = sum;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   initial begin
      op_type op;
      int s;
      int e;
      int k;
      int j;
      logic [31:0] v;
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_SUM;
      req_range_start = '0;
      req_range_end = '0;
      req_value = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      tag_chk = 1'b0;
      tag_sum = '0;
      idle_on = 1'b1;
      n_errs = 0;
      quiet_cycles = 0;
      shadow_len = ACTIVE_LENGTH_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) elem_shadow[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[r])
         send_word(dir_rows[r].op, dir_rows[r].s, dir_rows[r].e, dir_rows[r].v,
                   dir_rows[r].chk, dir_rows[r].sum);

      for (int p = 0; p < N_PHASES; p++) begin
         req_valid = 1'b0;
         while (pending_sums.size() != 0) @(negedge clock);
         // non-sum words may still be walking buckets
         repeat (DRAIN_CYCLES) @(negedge clock);
         csr_write(ADDR_ACTIVE_LENGTH, len_sets[p]);
         idle_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            op = (pick < 30) ? OP_ADD : (pick < 55) ? OP_ASSIGN :
                 (pick < 95) ? OP_SUM : OP_FILL;
            s = $urandom_range(0, STORE_DEPTH - 1);
            case ($urandom_range(0, 9))
               0: begin
                  s = 0;
                  e = STORE_DEPTH;
               end
               1: begin
                  k = $urandom_range(0, DEF_NUM_BUCKETS - 1);
                  j = $urandom_range(k, DEF_NUM_BUCKETS);
                  s = k * DEF_BUCKET_SIZE;
                  e = j * DEF_BUCKET_SIZE;
               end
               2: begin
                  e = s + $urandom_range(0, 40);
                  if (e > STORE_DEPTH) e = STORE_DEPTH;
               end
               3: e = $urandom_range(0, s);
               default: e = $urandom_range(s, STORE_DEPTH);
            endcase
            v = $urandom;
            case ($urandom_range(0, 11))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'hFFFF_FFFF;
               3: v = 32'h0000_0000;
               default: ;
            endcase
            send_word(op, s, e, v, 1'b0, 64'h0);
         end
      end

      req_valid = 1'b0;
      while (pending_sums.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errs == 0)
         $display("[bucketed_range_add_assign_sum] OK");
      else
         $display("[bucketed_range_add_assign_sum] ERROR");
      $finish;
   end

endmodule

>>> filelist.f
src/brasum_pkg.sv
src/bucketed_range_add_assign_sum.sv
tb/sv/tb_bucketed_range_add_assign_sum.sv
